// ===== rtl/core/kmst_pkg.sv =====
// kmst_pkg: shared types and constants for the Kruskal spanning tree block.
// No dependencies.
package kmst_pkg;

  localparam int unsigned VW = 6;
  localparam int unsigned WW = 16;
  localparam int unsigned SW = 22;

  typedef enum logic [0:0] {
    CMD_ADD = 1'b0,
    CMD_RUN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [WW-1:0] w;
    logic [VW-1:0]        a;
    logic [VW-1:0]        b;
  } edge_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_INIT,
    ST_FIND,
    ST_MERGE,
    ST_BUMP,
    ST_LAST
  } state_e;

  // true when p orders before q: weight, then first vertex, then second
  function automatic logic edge_before(edge_t p, edge_t q);
    logic r;
    if (p.w != q.w) r = (p.w < q.w);
    else if (p.a != q.a) r = (p.a < q.a);
    else r = (p.b < q.b);
    return r;
  endfunction

endpackage

// ===== rtl/core/kruskal_minimum_spanning_tree.sv =====
// Kruskal spanning tree. Edges are loaded one per start transfer (command_i = 0)
// and insertion-sorted on arrival in a chain of MAX_EDGES cells; busy stays low
// during an add. Edges past capacity or with an endpoint at or above
// MAX_VERTICES are dropped and flagged on dropped_edges_o. A run transfer
// (command_i = 1) raises busy, reloads the union-find RAM, then pops the edges
// smallest first. Each edge is popped, each end is followed parent by parent up
// to its root, and the two roots are merged if the edge is taken, with a rank
// bump when their ranks tie. Union by rank keeps every find within
// log2(MAX_VERTICES) hops (no path compression; roots and ranks come out the
// same). Tree edges and the closing total are strobed by valid_o for one cycle
// each; the receiver cannot stall them. busy drops in the cycle the closing
// item shows.
// Depends on kmst_pkg, kmst_sort_cell, kmst_ram.
module kruskal_minimum_spanning_tree #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   command_i,
  input  logic [5:0]             vertex_a_i,
  input  logic [5:0]             vertex_b_i,
  input  logic signed [15:0]     edge_weight_in_i,
  output logic                   valid_o,
  output logic                   chosen_o,
  output logic [5:0]             tree_vertex_a_o,
  output logic [5:0]             tree_vertex_b_o,
  output logic signed [15:0]     tree_edge_weight_o,
  output logic signed [21:0]     total_weight_o,
  output logic                   dropped_edges_o,
  output logic                   last_o
);
  localparam int unsigned VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned UW = VI + 3;

  kmst_pkg::state_e state_q, state_d;
  kmst_pkg::edge_t  cell_d [MAX_EDGES+2];
  logic             cell_v [MAX_EDGES+2];
  logic             cell_g [MAX_EDGES+1];
  kmst_pkg::edge_t  new_e;
  kmst_pkg::edge_t  head;
  logic             acc, ins, pop, clr, take;
  logic             valid_d, chosen_d, last_d;
  logic [CW-1:0]    cnt_q;
  logic             ovf_q;
  logic [VI-1:0]    ini_q;
  logic [VI-1:0]    cur_q, ra_q, rb_q;
  logic [2:0]       rka_q, rkb_q;
  logic             side_q;
  logic [VI:0]      nch_q;
  kmst_pkg::edge_t  e_q;
  logic signed [21:0] sum_q;
  logic             uf_we;
  logic [VI-1:0]    uf_addr;
  logic [UW-1:0]    uf_wdata, uf_rdata;
  logic [VI-1:0]    uf_par;
  logic [2:0]       uf_rank;

  assign new_e.w = edge_weight_in_i;
  assign new_e.a = vertex_a_i;
  assign new_e.b = vertex_b_i;
  assign acc     = start && !busy;
  assign ins     = acc && (command_i == kmst_pkg::CMD_ADD) &&
                   (cnt_q < CW'(MAX_EDGES)) &&
                   ({1'b0, vertex_a_i} < 7'(MAX_VERTICES)) &&
                   ({1'b0, vertex_b_i} < 7'(MAX_VERTICES));

  // dummy neighbors at both ends of the chain
  assign cell_d[0] = '0;
  assign cell_v[0] = 1'b1;
  assign cell_g[0] = 1'b0;
  assign cell_d[MAX_EDGES+1] = '0;
  assign cell_v[MAX_EDGES+1] = 1'b0;

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    kmst_sort_cell u_cell (
      .clk_i, .rst_ni,
      .clr_i      (clr),
      .ins_i      (ins),
      .new_i      (new_e),
      .left_i     (cell_d[i]),
      .left_vld_i (cell_v[i]),
      .left_gt_i  (cell_g[i]),
      .shift_i    (pop),
      .right_i    (cell_d[i+2]),
      .right_vld_i(cell_v[i+2]),
      .data_o     (cell_d[i+1]),
      .vld_o      (cell_v[i+1]),
      .gt_o       (cell_g[i+1])
    );
  end

  // cell 1 holds the smallest edge; a pop moves every edge one cell down
  assign head = cell_d[1];

  // union-find word: {rank, parent}
  kmst_ram #(
    .Width(UW),
    .Depth(MAX_VERTICES)
  ) u_uf_ram (
    .clk_i,
    .we_i   (uf_we),
    .addr_i (uf_addr),
    .wdata_i(uf_wdata),
    .rdata_o(uf_rdata)
  );

  assign uf_par  = uf_rdata[VI-1:0];
  assign uf_rank = uf_rdata[UW-1:VI];
  assign take    = (ra_q != rb_q) && (nch_q < (VI+1)'(MAX_VERTICES-1));

  always_comb begin
    state_d  = state_q;
    pop      = 1'b0;
    clr      = 1'b0;
    uf_we    = 1'b0;
    uf_addr  = cur_q;
    uf_wdata = '0;
    unique case (state_q)
      kmst_pkg::ST_IDLE: begin
        if (acc && command_i == kmst_pkg::CMD_RUN) state_d = kmst_pkg::ST_INIT;
      end
      kmst_pkg::ST_INIT: begin
        uf_we    = 1'b1;
        uf_addr  = ini_q;
        uf_wdata = {3'd0, ini_q};
        if (ini_q == VI'(MAX_VERTICES-1)) state_d = kmst_pkg::ST_SORT;
      end
      kmst_pkg::ST_SORT: begin
        if (!cell_v[1]) state_d = kmst_pkg::ST_LAST;
        else begin
          pop     = 1'b1;
          uf_addr = VI'(head.a);
          state_d = kmst_pkg::ST_FIND;
        end
      end
      kmst_pkg::ST_FIND: begin
        // read data holds the word of cur_q
        if (uf_par != cur_q) uf_addr = uf_par;
        else if (!side_q) uf_addr = VI'(e_q.b);
        else state_d = kmst_pkg::ST_MERGE;
      end
      kmst_pkg::ST_MERGE: begin
        state_d = kmst_pkg::ST_SORT;
        if (take) begin
          uf_we = 1'b1;
          if (rka_q > rkb_q) begin
            uf_addr  = rb_q;
            uf_wdata = {rkb_q, ra_q};
          end else begin
            uf_addr  = ra_q;
            uf_wdata = {rka_q, rb_q};
            if (rka_q == rkb_q) state_d = kmst_pkg::ST_BUMP;
          end
        end
      end
      kmst_pkg::ST_BUMP: begin
        uf_we    = 1'b1;
        uf_addr  = rb_q;
        uf_wdata = {rkb_q + 3'd1, rb_q};
        state_d  = kmst_pkg::ST_SORT;
      end
      kmst_pkg::ST_LAST: begin
        clr     = 1'b1;
        state_d = kmst_pkg::ST_IDLE;
      end
      default: state_d = kmst_pkg::ST_IDLE;
    endcase
  end

  assign busy     = (state_q != kmst_pkg::ST_IDLE);
  assign chosen_d = (state_q == kmst_pkg::ST_MERGE) && take;
  assign last_d   = (state_q == kmst_pkg::ST_LAST);
  assign valid_d  = chosen_d || last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= kmst_pkg::ST_IDLE;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      valid_o  <= 1'b0;
      last_o   <= 1'b0;
      chosen_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_o  <= valid_d;
      last_o   <= last_d;
      chosen_o <= chosen_d;
      if (state_q == kmst_pkg::ST_LAST) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (ins) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (acc && command_i == kmst_pkg::CMD_ADD) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // union-find walk and result datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      kmst_pkg::ST_IDLE: begin
        ini_q <= '0;
        sum_q <= '0;
        nch_q <= '0;
      end
      kmst_pkg::ST_INIT: begin
        ini_q <= ini_q + VI'(1);
      end
      kmst_pkg::ST_SORT: begin
        e_q    <= head;
        cur_q  <= VI'(head.a);
        side_q <= 1'b0;
      end
      kmst_pkg::ST_FIND: begin
        if (uf_par != cur_q) cur_q <= uf_par;
        else if (!side_q) begin
          ra_q   <= cur_q;
          rka_q  <= uf_rank;
          side_q <= 1'b1;
          cur_q  <= VI'(e_q.b);
        end else begin
          rb_q  <= cur_q;
          rkb_q <= uf_rank;
        end
      end
      kmst_pkg::ST_MERGE: begin
        if (take) begin
          sum_q              <= sum_q + 22'(e_q.w);
          nch_q              <= nch_q + (VI+1)'(1);
          tree_vertex_a_o    <= e_q.a;
          tree_vertex_b_o    <= e_q.b;
          tree_edge_weight_o <= e_q.w;
          total_weight_o     <= sum_q + 22'(e_q.w);
          dropped_edges_o    <= ovf_q;
        end
      end
      kmst_pkg::ST_LAST: begin
        tree_vertex_a_o    <= '0;
        tree_vertex_b_o    <= '0;
        tree_edge_weight_o <= '0;
        total_weight_o     <= sum_q;
        dropped_edges_o    <= ovf_q;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/kmst_sort_cell.sv =====
// kmst_sort_cell: one slot of the insertion-sort chain.
// Depends on kmst_pkg.
module kmst_sort_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           clr_i,
  input  logic           ins_i,
  input  kmst_pkg::edge_t new_i,
  input  kmst_pkg::edge_t left_i,
  input  logic           left_vld_i,
  input  logic           left_gt_i,
  input  logic           shift_i,
  input  kmst_pkg::edge_t right_i,
  input  logic           right_vld_i,
  output kmst_pkg::edge_t data_o,
  output logic           vld_o,
  output logic           gt_o
);
  kmst_pkg::edge_t d_q;
  logic            v_q;
  logic            wr;

  // new item sits before this slot's edge (or slot empty)
  assign gt_o   = !v_q || kmst_pkg::edge_before(new_i, d_q);
  assign data_o = d_q;
  assign vld_o  = v_q;
  // only the slots from the insert point up to the first empty one move
  assign wr     = ins_i && gt_o && left_vld_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (clr_i) begin
      v_q <= 1'b0;
    end else if (wr) begin
      v_q <= 1'b1;
    end else if (shift_i) begin
      v_q <= right_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      d_q <= left_gt_i ? left_i : new_i;
    end else if (shift_i) begin
      d_q <= right_i;
    end
  end
endmodule

// ===== rtl/core/kmst_ram.sv =====
// kmst_ram: generic single-port RAM with registered read.
// No dependencies.
module kmst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== rtl/core/kmst_checker.sv =====
// kmst_checker: port-level assertions for kruskal_minimum_spanning_tree.
// Bound to the top level below.
module kmst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic valid_o,
  input logic chosen_o,
  input logic last_o
);
  a_last_not_chosen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> !chosen_o) else $error("last with chosen");
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_o || chosen_o) |-> valid_o) else $error("flag without strobe");
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy) else $error("busy after last");
endmodule

bind kruskal_minimum_spanning_tree kmst_checker u_kmst_checker (
  .clk_i, .rst_ni, .busy, .valid_o, .chosen_o, .last_o
);
